[src/kwsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsm_pkg
// Shared types and constants of the k-way sorted merge block: command and
// result beats, status and operation codes, and the comparator control bundle.
// ----------------------------------------------------------------------------
package kwsm_pkg;

  localparam int unsigned LIST_COUNT_DEF = 8;
  localparam int unsigned LIST_DEPTH_DEF = 256;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned INDEX_W        = 3;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e                        opcode;
    logic [INDEX_W-1:0]         list_index;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  merged_value;
  } result_t;

  // Control of the shared minimum unit.
  typedef struct packed {
    logic clear;
    logic load;
  } min_ctrl_t;

endpackage

[src/kwsm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module kwsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/kwsm_min.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsm_min
// Shared signed comparator with a running-minimum register. Candidates are
// offered one per cycle; the first of several equal values is kept.
// ----------------------------------------------------------------------------
module kwsm_min #(
  parameter int unsigned TAG_W = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  kwsm_pkg::min_ctrl_t                ctrl_i,
  input  logic signed [kwsm_pkg::VALUE_W-1:0] value_i,
  input  logic [TAG_W-1:0]                   tag_i,
  output logic                               found_o,
  output logic signed [kwsm_pkg::VALUE_W-1:0] min_o,
  output logic [TAG_W-1:0]                   tag_o
);

  logic                                found_q, found_d;
  logic signed [kwsm_pkg::VALUE_W-1:0] best_q, best_d;
  logic [TAG_W-1:0]                    tag_q, tag_d;
  logic                                take;

  assign take = ctrl_i.load && (!found_q || (value_i < best_q));

  always_comb begin
    found_d = found_q;
    best_d  = best_q;
    tag_d   = tag_q;
    if (ctrl_i.clear) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
      best_d  = value_i;
      tag_d   = tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    tag_q  <= tag_d;
  end

  assign found_o = found_q;
  assign min_o   = best_q;
  assign tag_o   = tag_q;

endmodule

[src/k_way_sorted_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Merges LIST_COUNT FIFO lists of signed 32-bit values by popping the
// smallest list head; pushes append to one list.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; every command gives
// exactly one result beat, shown on result_o for one cycle with done_o high,
// and the receiver cannot stall it. A push keeps busy high in the push state
// only (the list pointers are read in the accept cycle, the element is
// written in the next). A pop keeps busy high in S_SCAN and S_POP: one shared
// comparator visits the list heads one a cycle, behind a pointer RAM read and
// an element RAM read, then the winning list's pointers are written back. The
// result beat is shown in the first cycle with busy low, and a new command may
// be taken in that same cycle. Elements live in one RAM of LIST_COUNT rows of
// 2**clog2(LIST_DEPTH) words; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module k_way_sorted_merge #(
  parameter int unsigned LIST_COUNT = kwsm_pkg::LIST_COUNT_DEF,
  parameter int unsigned LIST_DEPTH = kwsm_pkg::LIST_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  kwsm_pkg::cmd_t    cmd_i,
  output logic              busy,
  output logic              done_o,
  output kwsm_pkg::result_t result_o
);

  localparam int unsigned LW    = $clog2(LIST_COUNT);
  localparam int unsigned SW    = $clog2(LIST_DEPTH);
  localparam int unsigned OW    = $clog2(LIST_DEPTH + 1);
  localparam int unsigned PW    = SW + OW;
  localparam int unsigned TAG_W = LW + PW;
  localparam int unsigned IXW   = (LW > kwsm_pkg::INDEX_W) ? LW : kwsm_pkg::INDEX_W;
  localparam int unsigned EDEPTH = LIST_COUNT * (2 ** SW);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PUSH = 4'b0010,
    S_SCAN = 4'b0100,
    S_POP  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Captured push command.
  logic [LW-1:0]                       idx_q, idx_d;
  logic                                range_q, range_d;
  logic signed [kwsm_pkg::VALUE_W-1:0] val_q, val_d;

  // Scan pipeline: issue, pointer data, element data.
  logic [LW-1:0] nxt_q, nxt_d;
  logic          issue_q, issue_d;
  logic          b_v_q, b_v_d;
  logic          b_last_q, b_last_d;
  logic [LW-1:0] b_idx_q, b_idx_d;
  logic          c_v_q, c_v_d;
  logic          c_has_q, c_has_d;
  logic          c_last_q, c_last_d;
  logic [TAG_W-1:0] c_tag_q, c_tag_d;

  // Per-list pointer state: valid bits in flops, contents in a RAM.
  logic [LIST_COUNT-1:0] valid_q, valid_d;
  logic                  rd_valid_q;
  logic [LW-1:0]         ptr_raddr;
  logic [PW-1:0]         ptr_rdata;
  logic [PW-1:0]         ptr_eff;
  logic                  ptr_we;
  logic [LW-1:0]         ptr_waddr;
  logic [PW-1:0]         ptr_wdata;
  logic [SW-1:0]         rp;
  logic [OW-1:0]         occ;

  logic                        elem_we;
  logic [LW+SW-1:0]            elem_waddr;
  logic [LW+SW-1:0]            elem_raddr;
  logic [kwsm_pkg::VALUE_W-1:0] elem_rdata;

  // Push slot arithmetic.
  logic [SW:0]   slot_sum;
  logic [SW:0]   slot_wrap;
  logic [IXW-1:0] idx_ext;

  // Minimum unit.
  kwsm_pkg::min_ctrl_t                 min_ctrl;
  logic                                min_found;
  logic signed [kwsm_pkg::VALUE_W-1:0] min_val;
  logic [TAG_W-1:0]                    min_tag;
  logic [LW-1:0]                       w_idx;
  logic [SW-1:0]                       w_rp;
  logic [OW-1:0]                       w_occ;

  logic              done_q, done_d;
  kwsm_pkg::result_t result_q, result_d;

  assign busy = (state_q != S_IDLE);

  assign ptr_eff = rd_valid_q ? ptr_rdata : '0;
  assign rp      = ptr_eff[PW-1:OW];
  assign occ     = ptr_eff[OW-1:0];

  assign idx_ext = IXW'(cmd_i.list_index);

  assign slot_sum  = {1'b0, rp} + (SW+1)'(occ);
  assign slot_wrap = (slot_sum >= (SW+1)'(LIST_DEPTH)) ?
                     (slot_sum - (SW+1)'(LIST_DEPTH)) : slot_sum;

  assign w_idx = min_tag[TAG_W-1:PW];
  assign w_rp  = min_tag[PW-1:OW];
  assign w_occ = min_tag[OW-1:0];

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    range_d    = range_q;
    val_d      = val_q;
    nxt_d      = nxt_q;
    issue_d    = 1'b0;
    b_v_d      = 1'b0;
    b_last_d   = 1'b0;
    b_idx_d    = b_idx_q;
    c_v_d      = 1'b0;
    c_has_d    = 1'b0;
    c_last_d   = 1'b0;
    c_tag_d    = c_tag_q;
    valid_d    = valid_q;
    ptr_raddr  = '0;
    ptr_we     = 1'b0;
    ptr_waddr  = idx_q;
    ptr_wdata  = '0;
    elem_we    = 1'b0;
    elem_waddr = {idx_q, slot_wrap[SW-1:0]};
    elem_raddr = {b_idx_q, rp};
    min_ctrl   = '0;
    done_d     = 1'b0;
    result_d   = result_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (cmd_i.opcode == kwsm_pkg::OP_PUSH) begin
            ptr_raddr = idx_ext[LW-1:0];
            idx_d     = idx_ext[LW-1:0];
            range_d   = ({1'b0, idx_ext} < (IXW+1)'(LIST_COUNT));
            val_d     = cmd_i.value;
            state_d   = S_PUSH;
          end else begin
            // List 0 is issued right away; the rest follow one a cycle.
            ptr_raddr      = '0;
            b_v_d          = 1'b1;
            b_idx_d        = '0;
            nxt_d          = LW'(1);
            issue_d        = 1'b1;
            min_ctrl.clear = 1'b1;
            state_d        = S_SCAN;
          end
        end
      end

      S_PUSH: begin
        done_d                = 1'b1;
        result_d.merged_value = '0;
        if (!range_q || (occ == OW'(LIST_DEPTH))) begin
          result_d.status = kwsm_pkg::ST_FULL;
        end else begin
          result_d.status = kwsm_pkg::ST_OK;
          elem_we         = 1'b1;
          ptr_we          = 1'b1;
          ptr_waddr       = idx_q;
          ptr_wdata       = {rp, occ + 1'b1};
          valid_d[idx_q]  = 1'b1;
        end
        state_d = S_IDLE;
      end

      S_SCAN: begin
        if (issue_q) begin
          ptr_raddr = nxt_q;
          b_v_d     = 1'b1;
          b_idx_d   = nxt_q;
          b_last_d  = (nxt_q == LW'(LIST_COUNT - 1));
          issue_d   = (nxt_q != LW'(LIST_COUNT - 1));
          nxt_d     = nxt_q + 1'b1;
        end
        if (b_v_q) begin
          c_v_d    = 1'b1;
          c_has_d  = (occ != '0);
          c_last_d = b_last_q;
          c_tag_d  = {b_idx_q, rp, occ};
        end
        if (c_v_q) begin
          min_ctrl.load = c_has_q;
          if (c_last_q) begin
            state_d = S_POP;
          end
        end
      end

      S_POP: begin
        done_d = 1'b1;
        if (!min_found) begin
          result_d.status       = kwsm_pkg::ST_EMPTY;
          result_d.merged_value = '0;
        end else begin
          result_d.status       = kwsm_pkg::ST_OK;
          result_d.merged_value = min_val;
          ptr_we    = 1'b1;
          ptr_waddr = w_idx;
          ptr_wdata = {((w_rp == SW'(LIST_DEPTH - 1)) ? SW'(0) : (w_rp + 1'b1)),
                       w_occ - 1'b1};
        end
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issue_q  <= 1'b0;
      b_v_q    <= 1'b0;
      b_last_q <= 1'b0;
      c_v_q    <= 1'b0;
      c_has_q  <= 1'b0;
      c_last_q <= 1'b0;
      valid_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      issue_q  <= issue_d;
      b_v_q    <= b_v_d;
      b_last_q <= b_last_d;
      c_v_q    <= c_v_d;
      c_has_q  <= c_has_d;
      c_last_q <= c_last_d;
      valid_q  <= valid_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    range_q    <= range_d;
    val_q      <= val_d;
    nxt_q      <= nxt_d;
    b_idx_q    <= b_idx_d;
    c_tag_q    <= c_tag_d;
    rd_valid_q <= valid_q[ptr_raddr];
    result_q   <= result_d;
  end

  kwsm_ram #(
    .WIDTH (PW),
    .DEPTH (LIST_COUNT)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ptr_we),
    .waddr_i (ptr_waddr),
    .wdata_i (ptr_wdata),
    .raddr_i (ptr_raddr),
    .rdata_o (ptr_rdata)
  );

  kwsm_ram #(
    .WIDTH (kwsm_pkg::VALUE_W),
    .DEPTH (EDEPTH)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (elem_waddr),
    .wdata_i (val_q),
    .raddr_i (elem_raddr),
    .rdata_o (elem_rdata)
  );

  kwsm_min #(
    .TAG_W (TAG_W)
  ) u_min (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (min_ctrl),
    .value_i (elem_rdata),
    .tag_i   (c_tag_q),
    .found_o (min_found),
    .min_o   (min_val),
    .tag_o   (min_tag)
  );

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
